[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[rtl/mdd_pkg.sv]
package mdd_pkg;

  localparam int ADDR_W = 10;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] CMD_PAL_WR = 2'd0;
  localparam logic [1:0] CMD_PIXEL  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam int LUMA_R = 30;
  localparam int LUMA_G = 59;
  localparam int LUMA_B = 11;
  localparam int LUMA_DIV = 100;
  localparam int DITHER_STEP = 16;
  localparam int DITHER_BIAS = 8;

  // luma > thr  <=>  weighted sum >= LUMA_DIV * (thr + 1)
  localparam int LIMIT_STEP = LUMA_DIV * DITHER_STEP;
  localparam int LIMIT_BASE = LUMA_DIV * (DITHER_BIAS + 1);

  localparam logic [3:0] BAYER [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  typedef struct packed {
    logic [1:0]        command;
    logic              frame_start;
    logic [7:0]        pixel_index;
    logic [7:0]        palette_slot;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [ADDR_W-1:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pixel_written;
    logic       pixel_on;
    logic [6:0] out_col;
    logic [5:0] out_row;
    logic       frame_done;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_PAL_WR,
    OP_PIXEL,
    OP_READ,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [7:0]        index;
    logic [23:0]       rgb;
    logic [ADDR_W-1:0] addr;
    logic              written;
    logic [6:0]        out_col;
    logic [5:0]        out_row;
    logic              frame_done;
  } op_t;

  function automatic logic [14:0] dither_limit(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] lvl;
    lvl = BAYER[{row, col}];
    return 15'(lvl) * 15'(LIMIT_STEP) + 15'(LIMIT_BASE);
  endfunction

endpackage

[rtl/mdd_ram.sv]
module mdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mdd_queue.sv]
`include "assert_macros.svh"

module mdd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mdd_pkg::op_t  push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output mdd_pkg::op_t  head_data
);
  import mdd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(q_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `ASSERT_IMPLIES(q_pop_nonempty, clk, rst, pop, count != '0)
  `ASSERT_NEXT(q_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

[rtl/mdd_front.sv]
`include "assert_macros.svh"

module mdd_front #(
  parameter int SRC_W = 320,
  parameter int SRC_H = 200,
  parameter int OUT_W = 128,
  parameter int OUT_H = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  mdd_pkg::in_item_t item,
  output mdd_pkg::op_t      op
);
  import mdd_pkg::*;

  // Row target advances by SRC_H/OUT_H with a running remainder.
  localparam int ROW_Q = SRC_H / OUT_H;
  localparam int ROW_R = SRC_H % OUT_H;
  localparam int REM_W = $clog2(OUT_H);
  localparam int SUM_W = REM_W + 1;

  logic [8:0]       source_col, source_col_next;
  logic [7:0]       source_row, source_row_next;
  logic [6:0]       next_out_col, next_out_col_next;
  logic [5:0]       next_out_row, next_out_row_next;
  logic [8:0]       col_target, col_target_next;
  logic [7:0]       row_target, row_target_next;
  logic [REM_W-1:0] row_rem, row_rem_next;

  logic [8:0]       scol_e, ctgt_e;
  logic [7:0]       srow_e, rtgt_e;
  logic [6:0]       x;
  logic [5:0]       y;
  logic [REM_W-1:0] rem_e;
  logic             is_pix, row_kept, kept, col_last, row_last;
  logic [6:0]       x_inc;
  logic [8:0]       ctgt_inc;
  logic [SUM_W-1:0] rem_sum;
  logic             carry;

  assign is_pix = (item.command == CMD_PIXEL);

  always_comb begin
    if (item.frame_start) begin
      scol_e = '0;
      srow_e = '0;
      x      = '0;
      y      = '0;
      ctgt_e = '0;
      rtgt_e = '0;
      rem_e  = '0;
    end else begin
      scol_e = source_col;
      srow_e = source_row;
      x      = next_out_col;
      y      = next_out_row;
      ctgt_e = col_target;
      rtgt_e = row_target;
      rem_e  = row_rem;
    end
  end

  assign row_kept = (srow_e == rtgt_e);
  assign kept     = row_kept && (scol_e == ctgt_e);
  assign col_last = (scol_e >= 9'(SRC_W - 1));
  assign row_last = (srow_e >= 8'(SRC_H - 1));
  assign x_inc    = x + 1'b1;
  assign ctgt_inc = 9'((16'(x_inc) * 16'(SRC_W)) / OUT_W);
  assign rem_sum  = SUM_W'(rem_e) + SUM_W'(ROW_R);
  assign carry    = (rem_sum >= SUM_W'(OUT_H));

  always_comb begin
    source_col_next   = scol_e;
    source_row_next   = srow_e;
    next_out_col_next = x;
    next_out_row_next = y;
    col_target_next   = ctgt_e;
    row_target_next   = rtgt_e;
    row_rem_next      = rem_e;
    if (kept) begin
      next_out_col_next = x_inc;
      col_target_next   = ctgt_inc;
    end
    if (col_last) begin
      if (row_last) begin
        source_col_next   = '0;
        source_row_next   = '0;
        next_out_col_next = '0;
        next_out_row_next = '0;
        col_target_next   = '0;
        row_target_next   = '0;
        row_rem_next      = '0;
      end else begin
        source_col_next   = '0;
        source_row_next   = srow_e + 1'b1;
        next_out_col_next = '0;
        col_target_next   = '0;
        if (row_kept) begin
          next_out_row_next = y + 1'b1;
          row_target_next   = rtgt_e + 8'(ROW_Q) + 8'(carry);
          row_rem_next      = carry ? REM_W'(rem_sum - SUM_W'(OUT_H)) : REM_W'(rem_sum);
        end
      end
    end else begin
      source_col_next = scol_e + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_col   <= '0;
      source_row   <= '0;
      next_out_col <= '0;
      next_out_row <= '0;
      col_target   <= '0;
      row_target   <= '0;
      row_rem      <= '0;
    end else if (accept && is_pix) begin
      source_col   <= source_col_next;
      source_row   <= source_row_next;
      next_out_col <= next_out_col_next;
      next_out_row <= next_out_row_next;
      col_target   <= col_target_next;
      row_target   <= row_target_next;
      row_rem      <= row_rem_next;
    end
  end

  always_comb begin
    unique case (item.command)
      CMD_PAL_WR: op.kind = OP_PAL_WR;
      CMD_PIXEL:  op.kind = OP_PIXEL;
      CMD_READ:   op.kind = OP_READ;
      default:    op.kind = OP_NOP;
    endcase
    op.index      = is_pix ? item.pixel_index : item.palette_slot;
    op.rgb        = {item.red, item.green, item.blue};
    op.addr       = is_pix ? ADDR_W'((16'(y >> 3) * 16'(OUT_W)) + 16'(x)) : item.read_address;
    op.written    = is_pix && kept;
    op.out_col    = op.written ? x : '0;
    op.out_row    = op.written ? y : '0;
    op.frame_done = is_pix && col_last && row_last;
  end

  `ASSERT_NEXT(fr_frame_clear, clk, rst, accept && op.frame_done, (source_col == '0) && (source_row == '0))
  `ASSERT_IMPLIES(fr_row_range, clk, rst, accept && op.written, int'(op.out_row) < OUT_H)
  `ASSERT_IMPLIES(fr_flags_pixel, clk, rst, op.kind != OP_PIXEL, !op.written && !op.frame_done)

endmodule

[rtl/mdd_back.sv]
`include "assert_macros.svh"

module mdd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  mdd_pkg::op_t       head,
  output logic               pop,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output mdd_pkg::out_item_t rsp
);
  import mdd_pkg::*;

  logic              adv;
  logic              p1_valid, p2_valid;
  op_t               p1, p2;
  logic [14:0]       p2_sum;
  logic [14:0]       sum;
  logic [23:0]       pal_q;
  logic              pal_we;
  logic              st_re, st_we;
  logic [7:0]        st_q;
  logic              fwd;
  logic [7:0]        fwd_data;
  logic [7:0]        byte_in, byte_new, mask;
  logic              lit;

  // whole back end moves together; stalls only on the output register
  assign adv    = !rsp_valid || rsp_ready;
  assign pop    = head_valid && adv;
  assign pal_we = pop && (head.kind == OP_PAL_WR);

  mdd_ram #(.WIDTH(24), .DEPTH(256)) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (head.index),
    .wdata (head.rgb),
    .re    (pop),
    .raddr (head.index),
    .rdata (pal_q)
  );

  assign sum = 15'(pal_q[23:16]) * 15'(LUMA_R)
             + 15'(pal_q[15:8])  * 15'(LUMA_G)
             + 15'(pal_q[7:0])   * 15'(LUMA_B);

  assign st_re = adv && p1_valid && (p1.written || (p1.kind == OP_READ));
  assign st_we = adv && p2_valid && p2.written;

  mdd_ram #(.WIDTH(8), .DEPTH(1 << ADDR_W)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (p2.addr),
    .wdata (byte_new),
    .re    (st_re),
    .raddr (p1.addr),
    .rdata (st_q)
  );

  // read and write of the same byte on one edge: take the fresh value
  assign byte_in  = fwd ? fwd_data : st_q;
  assign lit      = (p2_sum >= dither_limit(p2.out_row[1:0], p2.out_col[1:0]));
  assign mask     = 8'b1 << p2.out_row[2:0];
  assign byte_new = lit ? (byte_in | mask) : (byte_in & ~mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      fwd       <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      p1_valid  <= head_valid;
      p2_valid  <= p1_valid;
      fwd       <= st_we && st_re && (p1.addr == p2.addr);
      rsp_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1                <= head;
      p2                <= p1;
      p2_sum            <= sum;
      fwd_data          <= byte_new;
      rsp.read_data     <= (p2.kind == OP_READ) ? byte_in : '0;
      rsp.pixel_written <= p2.written;
      rsp.pixel_on      <= p2.written && lit;
      rsp.out_col       <= p2.out_col;
      rsp.out_row       <= p2.out_row;
      rsp.frame_done    <= p2.frame_done;
    end
  end

  `ASSERT_IMPLIES(bk_fwd_user, clk, rst, fwd, p2_valid && (p2.written || (p2.kind == OP_READ)))
  `ASSERT_NEXT(bk_result_out, clk, rst, adv && p2_valid, rsp_valid)
  `ASSERT_IMPLIES(bk_on_written, clk, rst, rsp_valid && rsp.pixel_on, rsp.pixel_written)

endmodule

[rtl/mono_dither_downscaler.sv]
// Channel  Direction  Handshake             Beat
// req      in         req_valid/req_ready   mdd_pkg::in_item_t
// rsp      out        rsp_valid/rsp_ready   mdd_pkg::out_item_t
//
// One beat per cycle sustained unless rsp stalls; each palette and frame-store RAM port
// is used at most once per beat. Results pass the queue, p1, p2 and the rsp register.
// Reset clears counters, the 4-entry queue and pipeline valids; RAM contents are not cleared.
// rsp_ready low freezes the back end; req_ready drops once the queue is full.
module mono_dither_downscaler #(
  parameter int SRC_W = 320,
  parameter int SRC_H = 200,
  parameter int OUT_W = 128,
  parameter int OUT_H = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  mdd_pkg::in_item_t  req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output mdd_pkg::out_item_t rsp
);
  import mdd_pkg::*;

  logic accept;
  logic q_full;
  logic q_pop;
  logic head_valid;
  op_t  op;
  op_t  head;

  assign req_ready = !q_full;
  assign accept    = req_valid && req_ready;

  mdd_front #(
    .SRC_W (SRC_W),
    .SRC_H (SRC_H),
    .OUT_W (OUT_W),
    .OUT_H (OUT_H)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (req),
    .op     (op)
  );

  mdd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_data  (head)
  );

  mdd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule

[dv/tb_mono_dither_downscaler.sv]
`timescale 1ns / 1ps

module tb_mono_dither_downscaler;
  import mdd_pkg::*;

  localparam int SRC_W = 320;
  localparam int SRC_H = 200;
  localparam int OUT_W = 128;
  localparam int OUT_H = 64;
  localparam logic [1:0] CMD_UNUSED = 2'(OP_NOP);
  localparam int RANDOM_BEATS = 1550;
  localparam int PHASE_BEATS = 390;

  localparam out_item_t NO_RESULT = '0;
  localparam out_item_t LIT_ORIGIN = '{8'h00, 1'b1, 1'b1, 7'd0, 6'd0, 1'b0};
  localparam out_item_t DARK_ORIGIN = '{8'h00, 1'b1, 1'b0, 7'd0, 6'd0, 1'b0};

  typedef struct packed {
    in_item_t  stim;
    logic      known;
    out_item_t want;
  } directed_row_t;

  // known = 0: the predictor supplies the expected beat
  directed_row_t directed_rows [17] = '{
    '{'{CMD_PAL_WR, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000}, 1'b1, NO_RESULT},
    '{'{CMD_PAL_WR, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 10'h3ff}, 1'b1, NO_RESULT},
    '{'{CMD_PAL_WR, 1'b0, 8'h00, 8'h01, 8'h08, 8'h08, 8'h08, 10'h155}, 1'b1, NO_RESULT},
    '{'{CMD_PAL_WR, 1'b0, 8'h00, 8'h02, 8'h09, 8'h09, 8'h09, 10'h2aa}, 1'b1, NO_RESULT},
    '{'{CMD_PAL_WR, 1'b0, 8'hff, 8'ha5, 8'h80, 8'h40, 8'hc0, 10'h000}, 1'b1, NO_RESULT},
    '{'{CMD_UNUSED, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 10'h3ff}, 1'b1, NO_RESULT},
    '{'{CMD_PIXEL,  1'b1, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000}, 1'b1, LIT_ORIGIN},
    '{'{CMD_PIXEL,  1'b0, 8'h00, 8'h5a, 8'h12, 8'h34, 8'h56, 10'h0f0}, 1'b0, NO_RESULT},
    '{'{CMD_PIXEL,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000}, 1'b0, NO_RESULT},
    // grey 8 sits on the origin threshold, grey 9 just above it
    '{'{CMD_PIXEL,  1'b1, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000}, 1'b1, DARK_ORIGIN},
    '{'{CMD_PIXEL,  1'b1, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000}, 1'b1, LIT_ORIGIN},
    '{'{CMD_PIXEL,  1'b0, 8'ha5, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000}, 1'b0, NO_RESULT},
    '{'{CMD_PIXEL,  1'b0, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000}, 1'b0, NO_RESULT},
    // frame start on a palette write must not restart the raster
    '{'{CMD_PAL_WR, 1'b1, 8'h00, 8'ha5, 8'h00, 8'hff, 8'h00, 10'h000}, 1'b1, NO_RESULT},
    '{'{CMD_PIXEL,  1'b0, 8'ha5, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000}, 1'b0, NO_RESULT},
    '{'{CMD_PIXEL,  1'b0, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000}, 1'b0, NO_RESULT},
    '{'{CMD_UNUSED, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000}, 1'b1, NO_RESULT}
  };

  int gap_by_phase [4] = '{0, 47, 0, 26};
  int stall_by_phase [4] = '{0, 0, 47, 26};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  in_item_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  out_item_t rsp;

  // predictor state
  bit [7:0] pal_red [256];
  bit [7:0] pal_green [256];
  bit [7:0] pal_blue [256];
  bit pal_seen [256];
  bit [7:0] store_bytes [1024];
  bit [7:0] store_known [1024];
  int pal_slots [$];
  int full_bytes [$];
  logic [8:0] src_col;
  logic [7:0] src_row;
  logic [6:0] next_x;
  logic [5:0] next_y;
  logic [8:0] col_goal;
  logic [7:0] row_goal;

  out_item_t pending_results [$];
  out_item_t arrived_want;
  int mismatches = 0;
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;

  always #5 clk = ~clk;

  mono_dither_downscaler #(
    .SRC_W(SRC_W),
    .SRC_H(SRC_H),
    .OUT_W(OUT_W),
    .OUT_H(OUT_H)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  function automatic void restart_raster();
    src_col = '0;
    src_row = '0;
    next_x = '0;
    next_y = '0;
    col_goal = '0;
    row_goal = '0;
  endfunction

  function automatic out_item_t downscale_step(input in_item_t b);
    out_item_t r;
    logic row_hit;
    logic lit;
    int luma;
    int limit;
    int addr;
    logic [7:0] mask;
    r = '0;
    case (b.command)
      CMD_PAL_WR: begin
        pal_red[b.palette_slot] = b.red;
        pal_green[b.palette_slot] = b.green;
        pal_blue[b.palette_slot] = b.blue;
        if (!pal_seen[b.palette_slot]) begin
          pal_seen[b.palette_slot] = 1'b1;
          pal_slots.push_back(int'(b.palette_slot));
        end
      end
      CMD_READ: r.read_data = store_bytes[b.read_address];
      CMD_PIXEL: begin
        if (b.frame_start) restart_raster();
        row_hit = (src_row == row_goal);
        if (row_hit && src_col == col_goal) begin
          luma = (LUMA_R * int'(pal_red[b.pixel_index]) +
                  LUMA_G * int'(pal_green[b.pixel_index]) +
                  LUMA_B * int'(pal_blue[b.pixel_index])) / LUMA_DIV;
          limit = int'(BAYER[{next_y[1:0], next_x[1:0]}]) * DITHER_STEP + DITHER_BIAS;
          lit = luma > limit;
          addr = int'(next_x) + int'(next_y >> 3) * OUT_W;
          mask = 8'd1 << next_y[2:0];
          store_bytes[addr] = lit ? (store_bytes[addr] | mask) : (store_bytes[addr] & ~mask);
          if (store_known[addr] != 8'hff) begin
            store_known[addr] = store_known[addr] | mask;
            if (store_known[addr] == 8'hff) full_bytes.push_back(addr);
          end
          r.pixel_written = 1'b1;
          r.pixel_on = lit;
          r.out_col = next_x;
          r.out_row = next_y;
          next_x = next_x + 7'd1;
          col_goal = 9'(int'(next_x) * SRC_W / OUT_W);
        end
        if (src_col >= SRC_W - 1) begin
          if (src_row >= SRC_H - 1) begin
            r.frame_done = 1'b1;
            restart_raster();
          end else begin
            src_col = '0;
            src_row = src_row + 8'd1;
            next_x = '0;
            col_goal = '0;
            if (row_hit) begin
              next_y = next_y + 6'd1;
              row_goal = 8'(int'(next_y) * SRC_H / OUT_H);
            end
          end
        end else begin
          src_col = src_col + 9'd1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] colour_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_beat(input in_item_t b, input logic known, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= b;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = downscale_step(b);
    pending_results.push_back(known ? want : predicted);
  endtask

  // always spends at least one edge, so valid is never lowered and raised in one step
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result beat with nothing expected: %h", rsp);
      end else begin
        arrived_want = pending_results.pop_front();
        if (rsp !== arrived_want) begin
          mismatches++;
          if (rsp.read_data !== arrived_want.read_data)
            $error("read_data: expected %h, got %h", arrived_want.read_data, rsp.read_data);
          if (rsp.pixel_written !== arrived_want.pixel_written)
            $error("pixel_written: expected %b, got %b",
                   arrived_want.pixel_written, rsp.pixel_written);
          if (rsp.pixel_on !== arrived_want.pixel_on)
            $error("pixel_on: expected %b, got %b", arrived_want.pixel_on, rsp.pixel_on);
          if (rsp.out_col !== arrived_want.out_col)
            $error("out_col: expected %0d, got %0d", arrived_want.out_col, rsp.out_col);
          if (rsp.out_row !== arrived_want.out_row)
            $error("out_row: expected %0d, got %0d", arrived_want.out_row, rsp.out_row);
          if (rsp.frame_done !== arrived_want.frame_done)
            $error("frame_done: expected %b, got %b",
                   arrived_want.frame_done, rsp.frame_done);
        end
      end
    end
  end

  initial begin
    in_item_t b;
    int beats;
    int phase;
    int k;
    restart_raster();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      push_beat(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].want);
    drain();

    beats = 0;
    phase = 0;
    while (beats < RANDOM_BEATS) begin
      if (beats != 0 && beats % PHASE_BEATS == 0) begin
        drain();
        phase = (phase + 1) % 4;
        sender_gap_pct = gap_by_phase[phase];
        receiver_stall_pct = stall_by_phase[phase];
      end
      k = $urandom_range(0, 99);
      b.command = CMD_PIXEL;
      b.frame_start = 1'($urandom_range(0, 1));
      b.pixel_index = 8'(pal_slots[$urandom_range(0, pal_slots.size() - 1)]);
      b.palette_slot = 8'($urandom);
      b.red = colour_byte();
      b.green = colour_byte();
      b.blue = colour_byte();
      b.read_address = 10'($urandom);
      if (k < 4 || (k < 8 && full_bytes.size() == 0)) begin
        b.command = CMD_PAL_WR;
      end else if (k < 8) begin
        // only bytes whose eight bits have all been drawn are read back
        b.command = CMD_READ;
        b.read_address = 10'(full_bytes[$urandom_range(0, full_bytes.size() - 1)]);
      end else if (k < 10) begin
        b.command = CMD_UNUSED;
      end else if (src_col != 0 || src_row != 0) begin
        // occasional mid-frame restart
        b.frame_start = ($urandom_range(0, 199) == 0);
      end
      push_beat(b, 1'b0, NO_RESULT);
      beats++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("mono_dither_downscaler regression: pass");
    end else begin
      $display("mono_dither_downscaler regression: fail");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("mono_dither_downscaler regression: fail");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/mdd_pkg.sv
rtl/mdd_ram.sv
rtl/mdd_queue.sv
rtl/mdd_front.sv
rtl/mdd_back.sv
rtl/mono_dither_downscaler.sv
dv/tb_mono_dither_downscaler.sv
